/* sv/cau_pkg.sv */
// Shared types for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  // Per-item control that travels beside the datapath.
  typedef struct packed {
    op_t  op;
    logic neg_re;
    logic neg_im;
    logic dz;
  } ctl_t;

endpackage
`default_nettype wire

/* sv/cau_prod.sv */
// Product stage and sum stage: partial products, then real/imaginary numerators and |b|^2.
`default_nettype none
module cau_prod import cau_pkg::*; #(
  parameter int W = 32
) (
  input  wire logic                clk,
  input  wire logic                en1,
  input  wire logic                en2,
  input  wire logic [1:0]          op,
  input  wire logic signed [W-1:0] a_re,
  input  wire logic signed [W-1:0] a_im,
  input  wire logic signed [W-1:0] b_re,
  input  wire logic signed [W-1:0] b_im,
  output op_t                      op2,
  output logic [2*W:0]             num_re,
  output logic [2*W:0]             num_im,
  output logic [2*W-1:0]           den
);

  logic [2*W-1:0] p_rr, p_ii, p_ri, p_ir, q_rr, q_ii;
  logic [W:0]     as_re, as_im;
  op_t            op1;
  logic [2*W:0]   e_rr, e_ii, e_ri, e_ir, num_re_next, num_im_next;

  always_ff @(posedge clk) begin
    if (en1) begin
      p_rr <= (2*W)'(a_re) * (2*W)'(b_re);
      p_ii <= (2*W)'(a_im) * (2*W)'(b_im);
      p_ri <= (2*W)'(a_re) * (2*W)'(b_im);
      p_ir <= (2*W)'(a_im) * (2*W)'(b_re);
      q_rr <= (2*W)'(b_re) * (2*W)'(b_re);
      q_ii <= (2*W)'(b_im) * (2*W)'(b_im);
      op1  <= op_t'(op);
      if (op_t'(op) == OP_SUB) begin
        as_re <= {a_re[W-1], a_re} - {b_re[W-1], b_re};
        as_im <= {a_im[W-1], a_im} - {b_im[W-1], b_im};
      end else begin
        as_re <= {a_re[W-1], a_re} + {b_re[W-1], b_re};
        as_im <= {a_im[W-1], a_im} + {b_im[W-1], b_im};
      end
    end
  end

  assign e_rr = {p_rr[2*W-1], p_rr};
  assign e_ii = {p_ii[2*W-1], p_ii};
  assign e_ri = {p_ri[2*W-1], p_ri};
  assign e_ir = {p_ir[2*W-1], p_ir};

  always_comb begin
    case (op1)
      OP_MUL: begin
        num_re_next = e_rr - e_ii;
        num_im_next = e_ri + e_ir;
      end
      OP_DIV: begin
        num_re_next = e_rr + e_ii;
        num_im_next = e_ir - e_ri;
      end
      default: begin
        num_re_next = {{W{as_re[W]}}, as_re};
        num_im_next = {{W{as_im[W]}}, as_im};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      num_re <= num_re_next;
      num_im <= num_im_next;
      den    <= q_rr + q_ii;
      op2    <= op1;
    end
  end

endmodule
`default_nettype wire

/* sv/cau_sign.sv */
// Sign/magnitude stage: splits each numerator into sign and magnitude and aligns it.
`default_nettype none
module cau_sign import cau_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  op_t                 op_in,
  input  wire logic [2*W:0]   num_re,
  input  wire logic [2*W:0]   num_im,
  input  wire logic [2*W-1:0] den_in,
  output ctl_t                ctl,
  output logic [3*W+F-1:0]    r_re,
  output logic [3*W+F-1:0]    r_im,
  output logic [2*W-1:0]      den
);

  localparam int RW = 3 * W + F;

  logic [2*W:0]  mag_re, mag_im;
  logic [RW-1:0] ext_re, ext_im, r_re_next, r_im_next;

  assign mag_re = num_re[2*W] ? (~num_re + 1'b1) : num_re;
  assign mag_im = num_im[2*W] ? (~num_im + 1'b1) : num_im;
  assign ext_re = {{(RW-2*W-1){1'b0}}, mag_re};
  assign ext_im = {{(RW-2*W-1){1'b0}}, mag_im};

  // Multiply drops the fraction bits; divide scales the numerator up before the quotient.
  always_comb begin
    case (op_in)
      OP_MUL: begin
        r_re_next = ext_re >> F;
        r_im_next = ext_im >> F;
      end
      OP_DIV: begin
        r_re_next = ext_re << F;
        r_im_next = ext_im << F;
      end
      default: begin
        r_re_next = ext_re;
        r_im_next = ext_im;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.op     <= op_in;
      ctl.neg_re <= num_re[2*W];
      ctl.neg_im <= num_im[2*W];
      ctl.dz     <= (op_in == OP_DIV) && (den_in == '0);
      r_re       <= r_re_next;
      r_im       <= r_im_next;
      den        <= den_in;
    end
  end

endmodule
`default_nettype wire

/* sv/cau_div_step.sv */
// One restoring-division stage: produces one quotient bit for both parts.
`default_nettype none
module cau_div_step import cau_pkg::*; #(
  parameter int W     = 32,
  parameter int F     = 16,
  parameter int SHIFT = 0
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  ctl_t                  ctl_in,
  input  wire logic [2*W-1:0]   den_in,
  input  wire logic [3*W+F-1:0] r_re_in,
  input  wire logic [3*W+F-1:0] r_im_in,
  input  wire logic [W:0]       q_re_in,
  input  wire logic [W:0]       q_im_in,
  output ctl_t                  ctl,
  output logic [2*W-1:0]        den,
  output logic [3*W+F-1:0]      r_re,
  output logic [3*W+F-1:0]      r_im,
  output logic [W:0]            q_re,
  output logic [W:0]            q_im
);

  localparam int RW = 3 * W + F;

  logic [RW-1:0] dsh;
  logic          bit_re, bit_im;

  assign dsh    = {{(RW-2*W){1'b0}}, den_in} << SHIFT;
  // Other operations ride through with their magnitude untouched.
  assign bit_re = (ctl_in.op == OP_DIV) && (r_re_in >= dsh);
  assign bit_im = (ctl_in.op == OP_DIV) && (r_im_in >= dsh);

  always_ff @(posedge clk) begin
    if (en) begin
      ctl  <= ctl_in;
      den  <= den_in;
      r_re <= bit_re ? (r_re_in - dsh) : r_re_in;
      r_im <= bit_im ? (r_im_in - dsh) : r_im_in;
      q_re <= {q_re_in[W-1:0], bit_re};
      q_im <= {q_im_in[W-1:0], bit_im};
    end
  end

endmodule
`default_nettype wire

/* sv/cau_sat.sv */
// Output stage: saturation, sign restore and status.
`default_nettype none
module cau_sat import cau_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  ctl_t                  ctl,
  input  wire logic [3*W+F-1:0] r_re,
  input  wire logic [3*W+F-1:0] r_im,
  input  wire logic [W:0]       q_re,
  input  wire logic [W:0]       q_im,
  output logic signed [W-1:0]   res_re,
  output logic signed [W-1:0]   res_im,
  output logic [1:0]            status
);

  localparam int RW = 3 * W + F;
  localparam logic [RW-1:0] HALF = {{(RW-1){1'b0}}, 1'b1} << (W-1);

  logic [RW-1:0] m_re, m_im, lim_re, lim_im, s_re, s_im;
  logic          ov_re, ov_im;
  logic [W-1:0]  v_re, v_im;

  assign m_re   = (ctl.op == OP_DIV) ? {{(RW-W-1){1'b0}}, q_re} : r_re;
  assign m_im   = (ctl.op == OP_DIV) ? {{(RW-W-1){1'b0}}, q_im} : r_im;
  assign lim_re = ctl.neg_re ? HALF : HALF - 1'b1;
  assign lim_im = ctl.neg_im ? HALF : HALF - 1'b1;
  assign ov_re  = m_re > lim_re;
  assign ov_im  = m_im > lim_im;
  assign s_re   = ov_re ? lim_re : m_re;
  assign s_im   = ov_im ? lim_im : m_im;
  assign v_re   = s_re[W-1:0];
  assign v_im   = s_im[W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl.dz) begin
        res_re <= '0;
        res_im <= '0;
        status <= ST_DZ;
      end else begin
        res_re <= ctl.neg_re ? (~v_re + 1'b1) : v_re;
        res_im <= ctl.neg_im ? (~v_im + 1'b1) : v_im;
        status <= (ov_re || ov_im) ? ST_OVF : ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/complex_arith_unit.sv */
// Top level of the pipelined complex arithmetic unit.
// Computes a+b, a-b, a*b or a/b on signed fixed-point complex operands with
// DATA_WIDTH-bit parts and FRAC_BITS fraction bits, truncating toward zero and saturating.
// One operation is taken every cycle unless back-pressure holds in_ready low; the data passes
// DATA_WIDTH+5 register stages, a depth set by the long division, which resolves one
// quotient bit per stage. Every stage holds its own valid bit and stalls only when the
// stage after it is full and blocked, so empty slots close up under back-pressure.
`default_nettype none
module complex_arith_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   op,
  input  wire logic signed [DATA_WIDTH-1:0] a_re,
  input  wire logic signed [DATA_WIDTH-1:0] a_im,
  input  wire logic signed [DATA_WIDTH-1:0] b_re,
  input  wire logic signed [DATA_WIDTH-1:0] b_im,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      res_re,
  output logic signed [DATA_WIDTH-1:0]      res_im,
  output logic [1:0]                        status
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int RW = 3 * W + F;
  localparam int NS = W + 5;
  localparam int NQ = W + 1;

  logic [NS-1:0] v, en;

  // Stage handshake: a stage may load when empty or when it empties this cycle.
  assign en[NS-1] = !v[NS-1] || out_ready;
  for (genvar k = 0; k < NS-1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= (k == 0) ? in_valid : v[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  op_t            op2;
  logic [2*W:0]   num_re, num_im;
  logic [2*W-1:0] den2;

  cau_prod #(.W(W)) u_prod (
    .clk(clk), .en1(en[0]), .en2(en[1]), .op(op),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .op2(op2), .num_re(num_re), .num_im(num_im), .den(den2)
  );

  ctl_t           ctl_c [NQ+1];
  logic [2*W-1:0] den_c [NQ+1];
  logic [RW-1:0]  r_re_c [NQ+1];
  logic [RW-1:0]  r_im_c [NQ+1];
  logic [W:0]     q_re_c [NQ+1];
  logic [W:0]     q_im_c [NQ+1];

  cau_sign #(.W(W), .F(F)) u_sign (
    .clk(clk), .en(en[2]), .op_in(op2), .num_re(num_re), .num_im(num_im),
    .den_in(den2), .ctl(ctl_c[0]), .r_re(r_re_c[0]), .r_im(r_im_c[0]),
    .den(den_c[0])
  );

  assign q_re_c[0] = '0;
  assign q_im_c[0] = '0;

  for (genvar j = 0; j < NQ; j++) begin : g_div
    cau_div_step #(.W(W), .F(F), .SHIFT(W-j)) u_step (
      .clk(clk), .en(en[3+j]),
      .ctl_in(ctl_c[j]), .den_in(den_c[j]),
      .r_re_in(r_re_c[j]), .r_im_in(r_im_c[j]),
      .q_re_in(q_re_c[j]), .q_im_in(q_im_c[j]),
      .ctl(ctl_c[j+1]), .den(den_c[j+1]),
      .r_re(r_re_c[j+1]), .r_im(r_im_c[j+1]),
      .q_re(q_re_c[j+1]), .q_im(q_im_c[j+1])
    );
  end

  cau_sat #(.W(W), .F(F)) u_sat (
    .clk(clk), .en(en[NS-1]), .ctl(ctl_c[NQ]),
    .r_re(r_re_c[NQ]), .r_im(r_im_c[NQ]),
    .q_re(q_re_c[NQ]), .q_im(q_im_c[NQ]),
    .res_re(res_re), .res_im(res_im), .status(status)
  );

endmodule
`default_nettype wire

/* sv/cau_checker.sv */
// Port-level checks for the complex arithmetic unit, bound to the top level.
`default_nettype none
module cau_checker import cau_pkg::*; #(
  parameter int W = 32
) (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire logic [W-1:0] res_re,
  input wire logic [W-1:0] res_im,
  input wire logic [1:0]   status
);

  a_no_unused_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_OVF || status == ST_DZ))
    else $error("status shows the unused code");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_DZ) |-> (res_re == '0 && res_im == '0))
    else $error("zero-divisor result is not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(res_re) && $stable(res_im)
                                   && $stable(status)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind complex_arith_unit cau_checker #(.W(DATA_WIDTH)) u_cau_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .res_re(res_re), .res_im(res_im), .status(status)
);
`default_nettype wire
